### sv/cal_pkg.sv
// ---------------------------------------------------------------------------
// cal_pkg
// Shared defaults and codes for the cursor array list unit and its element RAM.
// ---------------------------------------------------------------------------
package cal_pkg;

  localparam int unsigned CAL_DEPTH      = 16;
  localparam int unsigned CAL_ELEM_WIDTH = 32;

  // request modes
  typedef enum logic [3:0] {
    M_READ  = 4'd0,
    M_PREV  = 4'd1,
    M_NEXT  = 4'd2,
    M_FIRST = 4'd3,
    M_LAST  = 4'd4,
    M_DEL   = 4'd5,
    M_INS_B = 4'd6,
    M_INS_A = 4'd7,
    M_INDEX = 4'd8
  } cal_mode_t;

  // result status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } cal_status_t;

endpackage

### sv/cursor_array_list_unit.sv
// ---------------------------------------------------------------------------
// cursor_array_list_unit
// Ordered list of up to DEPTH words with a cursor, held in one RAM.
// ---------------------------------------------------------------------------
// One item is handled at a time. Read, prev, next, first, last and index read
// pass through decode, a RAM read, capture and emit; non-insert requests on an
// empty list, a full-store insert, an out-of-range index and unknown modes go
// from decode straight to emit. Delete and insert move the later elements
// through the single RAM port pair, one element per cycle, shifting up to
// DEPTH - 1 elements; an insert then writes the new word. The result sits
// in an output register; the next item is taken as soon as the unit is
// back in idle, even while that result still waits to be taken.
module cursor_array_list_unit
  import cal_pkg::*;
#(
  parameter int unsigned DEPTH      = CAL_DEPTH,
  parameter int unsigned ELEM_WIDTH = CAL_ELEM_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_mode,
  input  logic [31:0] in_value,
  input  logic [3:0]  in_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_data,
  output logic [1:0]  out_status,
  output logic        out_moved,
  output logic [4:0]  out_length,
  output logic [3:0]  out_position
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam int unsigned DW    = (ELEM_WIDTH > 32) ? ELEM_WIDTH : 32;
  localparam int unsigned LW    = (CNT_W > 5) ? CNT_W : 5;
  localparam int unsigned PW    = (IDX_W > 4) ? IDX_W : 4;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SHIFT, S_WORD, S_READ, S_CAPT, S_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      cur_r, cur_nxt;
  logic [3:0]            mode_r, mode_nxt;
  logic [ELEM_WIDTH-1:0] word_r, word_nxt;
  logic [3:0]            idx_r, idx_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [IDX_W-1:0]      src_r, src_nxt;
  logic [IDX_W-1:0]      wa_r, wa_nxt;
  logic [IDX_W-1:0]      slot_r, slot_nxt;
  logic                  pend_r, pend_nxt;
  logic                  del_r, del_nxt;
  logic [ELEM_WIDTH-1:0] res_data_r, res_data_nxt;
  logic [1:0]            res_status_r, res_status_nxt;
  logic                  res_moved_r, res_moved_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ELEM_WIDTH-1:0] out_data_r, out_data_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic                  out_moved_r, out_moved_nxt;
  logic [CNT_W-1:0]      out_len_r, out_len_nxt;
  logic [IDX_W-1:0]      out_pos_r, out_pos_nxt;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ELEM_WIDTH-1:0] ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [ELEM_WIDTH-1:0] ram_rdata;

  logic                  empty;
  logic [CNT_W-1:0]      cur_ext;
  logic [CNT_W-1:0]      slot_ext;
  logic [CNT_W-1:0]      newc;
  logic [CMP_W-1:0]      idx_cmp;
  logic [DW-1:0]         value_ext;
  logic [DW-1:0]         data_ext;
  logic [LW-1:0]         len_ext;
  logic [PW-1:0]         pos_ext;

  cal_ram #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH),
    .ADDR_W     (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign value_ext = DW'(in_value);
  assign empty     = (count_r == '0);
  assign cur_ext   = CNT_W'(cur_r);
  assign idx_cmp   = CMP_W'(idx_r);
  assign newc      = count_r - CNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    mode_nxt       = mode_r;
    word_nxt       = word_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    src_nxt        = src_r;
    wa_nxt         = wa_r;
    slot_nxt       = slot_r;
    pend_nxt       = pend_r;
    del_nxt        = del_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    res_moved_nxt  = res_moved_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_moved_nxt  = out_moved_r;
    out_len_nxt    = out_len_r;
    out_pos_nxt    = out_pos_r;
    ram_we         = 1'b0;
    ram_waddr      = wa_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = cur_r;
    slot_ext       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          word_nxt  = value_ext[ELEM_WIDTH-1:0];
          idx_nxt   = in_index;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        res_status_nxt = ST_OK;
        res_moved_nxt  = 1'b0;
        res_data_nxt   = '0;
        pend_nxt       = 1'b0;
        state_nxt      = S_READ;
        if (empty && (mode_r <= M_DEL || mode_r == M_INDEX)) begin
          res_status_nxt = ST_EMPTY;
          state_nxt      = S_EMIT;
        end else begin
          case (mode_r)
            M_READ: ;
            M_PREV: begin
              if (cur_r != '0) begin
                cur_nxt       = cur_r - IDX_W'(1);
                res_moved_nxt = 1'b1;
              end
            end
            M_NEXT: begin
              if (CNT_W'(cur_ext + CNT_W'(1)) < count_r) begin
                cur_nxt       = cur_r + IDX_W'(1);
                res_moved_nxt = 1'b1;
              end
            end
            M_FIRST: cur_nxt = '0;
            M_LAST:  cur_nxt = IDX_W'(newc);
            M_DEL: begin
              // close the gap: move cursor+1 .. count-1 down by one
              n_nxt     = newc - cur_ext;
              src_nxt   = IDX_W'(cur_ext + CNT_W'(1));
              del_nxt   = 1'b1;
              state_nxt = S_SHIFT;
            end
            M_INS_B, M_INS_A: begin
              if (count_r >= CNT_W'(DEPTH)) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_EMIT;
              end else begin
                if (empty) begin
                  slot_ext = '0;
                end else if (mode_r == M_INS_B) begin
                  slot_ext = cur_ext;
                end else begin
                  slot_ext = CNT_W'(cur_ext + CNT_W'(1));
                end
                // open a gap: move count-1 down to slot up by one
                n_nxt     = count_r - slot_ext;
                src_nxt   = IDX_W'(newc);
                slot_nxt  = IDX_W'(slot_ext);
                del_nxt   = 1'b0;
                state_nxt = S_SHIFT;
              end
            end
            M_INDEX: begin
              if (!(idx_cmp < CMP_W'(count_r))) begin
                res_status_nxt = ST_RANGE;
                state_nxt      = S_EMIT;
              end
            end
            default: state_nxt = S_EMIT;
          endcase
        end
      end

      S_SHIFT: begin
        // write back the word read last cycle while fetching the next one
        ram_we    = pend_r;
        ram_waddr = wa_r;
        ram_wdata = ram_rdata;
        ram_raddr = src_r;
        if (n_r != '0) begin
          pend_nxt = 1'b1;
          wa_nxt   = del_r ? (src_r - IDX_W'(1)) : (src_r + IDX_W'(1));
          src_nxt  = del_r ? (src_r + IDX_W'(1)) : (src_r - IDX_W'(1));
          n_nxt    = n_r - CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (!del_r) begin
              state_nxt = S_WORD;
            end else begin
              count_nxt = newc;
              if (newc == '0) begin
                cur_nxt   = '0;
                state_nxt = S_EMIT;
              end else begin
                if (cur_ext >= newc) begin
                  cur_nxt = IDX_W'(newc - CNT_W'(1));
                end
                state_nxt = S_READ;
              end
            end
          end
        end
      end

      S_WORD: begin
        ram_we    = 1'b1;
        ram_waddr = slot_r;
        ram_wdata = word_r;
        count_nxt = count_r + CNT_W'(1);
        if (empty) begin
          cur_nxt = '0;
        end else if (mode_r == M_INS_B) begin
          cur_nxt = cur_r + IDX_W'(1);
        end
        state_nxt = S_READ;
      end

      S_READ: begin
        ram_raddr = (mode_r == M_INDEX) ? IDX_W'(idx_cmp) : cur_r;
        state_nxt = S_CAPT;
      end

      S_CAPT: begin
        res_data_nxt = ram_rdata;
        state_nxt    = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_status_nxt = res_status_r;
          out_moved_nxt  = res_moved_r;
          out_len_nxt    = count_r;
          out_pos_nxt    = cur_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      cur_r        <= cur_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
      mode_r       <= mode_nxt;
      word_r       <= word_nxt;
      idx_r        <= idx_nxt;
      n_r          <= n_nxt;
      src_r        <= src_nxt;
      wa_r         <= wa_nxt;
      slot_r       <= slot_nxt;
      del_r        <= del_nxt;
      res_data_r   <= res_data_nxt;
      res_status_r <= res_status_nxt;
      res_moved_r  <= res_moved_nxt;
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
      out_moved_r  <= out_moved_nxt;
      out_len_r    <= out_len_nxt;
      out_pos_r    <= out_pos_nxt;
    end
  end

  assign data_ext     = DW'(out_data_r);
  assign len_ext      = LW'(out_len_r);
  assign pos_ext      = PW'(out_pos_r);
  assign out_valid    = out_valid_r;
  assign out_data     = data_ext[31:0];
  assign out_status   = out_status_r;
  assign out_moved    = out_moved_r;
  assign out_length   = len_ext[4:0];
  assign out_position = pos_ext[3:0];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count above depth");

  a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) ? (cur_r == '0) : (cur_ext < count_r))
    else $error("cursor outside the list");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == CNT_W'($past(count_r) + CNT_W'(1)) ||
       CNT_W'(count_r + CNT_W'(1)) == $past(count_r)))
    else $error("element count changed by more than one");

  a_shift_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && pend_r) |-> (CNT_W'(wa_r) <= count_r))
    else $error("shift writes beyond the list");

endmodule

### sv/cal_ram.sv
// ---------------------------------------------------------------------------
// cal_ram
// Element store: one write port, one read port, read data registered.
// A read and a write to the same address on one edge return the old word.
// ---------------------------------------------------------------------------
module cal_ram
  import cal_pkg::*;
#(
  parameter int unsigned DEPTH      = CAL_DEPTH,
  parameter int unsigned ELEM_WIDTH = CAL_ELEM_WIDTH,
  parameter int unsigned ADDR_W     = $clog2(CAL_DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  logic [ELEM_WIDTH-1:0] wdata,
  input  logic [ADDR_W-1:0]     raddr,
  output logic [ELEM_WIDTH-1:0] rdata
);

  logic [ELEM_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### tb/tb_cursor_array_list_unit.sv
// ---------------------------------------------------------------------------
// tb_cursor_array_list_unit
// Self-checking bench for the cursor array list unit. A short table of
// requests covers the empty list, both inserts, cursor moves at the ends,
// index reads out of range, a full store and deletes at the edges. Random
// requests then drift between growing, shrinking and mixed traffic. Every
// result is checked field by field against an in-bench list model or a
// table row, with random idling on both sides and one long output hold-off.
// ---------------------------------------------------------------------------
module tb_cursor_array_list_unit
  import cal_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] MODE_UNUSED_FIRST = 4'd9;
  localparam logic [3:0] MODE_UNUSED_LAST  = 4'd15;

  typedef enum int {DRIFT_GROW, DRIFT_SHRINK, DRIFT_MIX} drift_t;

  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  status;
    logic        moved;
    logic [4:0]  length;
    logic [3:0]  position;
  } list_result_t;

  typedef struct {
    logic [3:0]   mode;
    logic [31:0]  value;
    logic [3:0]   index;
    int           reps;
    bit           fixed;
    list_result_t want;
  } stim_row_t;

  localparam int RANDOM_ITEMS = 1110;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_mode = '0;
  logic [31:0] in_value = '0;
  logic [3:0]  in_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_data;
  logic [1:0]  out_status;
  logic        out_moved;
  logic [4:0]  out_length;
  logic [3:0]  out_position;

  cursor_array_list_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_value     (in_value),
    .in_index     (in_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .out_status   (out_status),
    .out_moved    (out_moved),
    .out_length   (out_length),
    .out_position (out_position)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // List model state
  logic [31:0] list_words [CAL_DEPTH];
  int          list_len = 0;
  int          list_cur = 0;

  list_result_t pending_results [$];
  int requests_sent   = 0;
  int results_checked = 0;
  int error_count     = 0;
  int cycle_count     = 0;
  int empty_hits      = 0;
  int full_hits       = 0;
  int range_hits      = 0;
  int moved_hits      = 0;
  int peak_len        = 0;
  int mode_hits [16];

  function automatic list_result_t list_apply(logic [3:0] mode, logic [31:0] word,
                                              logic [3:0] idx);
    list_result_t r;
    bit           show;
    int           slot;
    int           i;
    r = '0;
    show = 1'b0;
    if (mode <= M_DEL || mode == M_INDEX) begin
      if (list_len == 0) begin
        r.status = ST_EMPTY;
      end else begin
        case (mode)
          M_READ: show = 1'b1;
          M_PREV: begin
            if (list_cur > 0) begin
              list_cur--;
              r.moved = 1'b1;
            end
            show = 1'b1;
          end
          M_NEXT: begin
            if (list_cur + 1 < list_len) begin
              list_cur++;
              r.moved = 1'b1;
            end
            show = 1'b1;
          end
          M_FIRST: begin
            list_cur = 0;
            show = 1'b1;
          end
          M_LAST: begin
            list_cur = list_len - 1;
            show = 1'b1;
          end
          M_DEL: begin
            for (i = list_cur; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
            list_len--;
            if (list_len == 0) list_cur = 0;
            else if (list_cur >= list_len) list_cur = list_len - 1;
            show = 1'b1;
          end
          default: begin
            if (idx < list_len) r.data = list_words[idx];
            else r.status = ST_RANGE;
          end
        endcase
      end
    end else if (mode == M_INS_B || mode == M_INS_A) begin
      if (list_len == 0) begin
        list_words[0] = word;
        list_len = 1;
        list_cur = 0;
        show = 1'b1;
      end else if (list_len >= CAL_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot = (mode == M_INS_B) ? list_cur : list_cur + 1;
        for (i = list_len; i > slot; i--) list_words[i] = list_words[i - 1];
        list_words[slot] = word;
        list_len++;
        // the cursor follows its element when something lands in front of it
        if (mode == M_INS_B) list_cur++;
        show = 1'b1;
      end
    end
    if (show && list_len > 0 && list_cur < list_len) r.data = list_words[list_cur];
    r.length = list_len[4:0];
    r.position = list_cur[3:0];
    return r;
  endfunction

  function automatic stim_row_t row(logic [3:0] m, logic [31:0] v, logic [3:0] ix,
                                    int reps = 1, bit fixed = 1'b0,
                                    list_result_t want = '0);
    stim_row_t s;
    s.mode = m;
    s.value = v;
    s.index = ix;
    s.reps = reps;
    s.fixed = fixed;
    s.want = want;
    return s;
  endfunction

  function automatic logic [3:0] pick_mode(drift_t d);
    int r;
    int ins_lim;
    int del_lim;
    int m;
    r = $urandom_range(0, 99);
    case (d)
      DRIFT_GROW: begin
        ins_lim = 50;
        del_lim = 60;
      end
      DRIFT_SHRINK: begin
        ins_lim = 10;
        del_lim = 55;
      end
      default: begin
        ins_lim = 25;
        del_lim = 40;
      end
    endcase
    if (r < ins_lim) return ($urandom_range(0, 1) != 0) ? M_INS_A : M_INS_B;
    if (r < del_lim) return M_DEL;
    if (r < 96) begin
      m = $urandom_range(0, 5);
      return (m == 5) ? M_INDEX : 4'(m);
    end
    return 4'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'h0;
    if (r < 10) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [3:0] pick_index();
    if (list_len > 0 && $urandom_range(0, 3) != 0) return 4'($urandom_range(0, list_len - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic offer(logic [3:0] mode, logic [31:0] value, logic [3:0] idx,
                       bit fixed, list_result_t want);
    list_result_t pred;
    // keep the input side busy through one stretch
    if (!(requests_sent >= 200 && requests_sent < 400) && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_value <= value;
    in_index <= idx;
    do @(posedge clk); while (in_stall);
    pred = list_apply(mode, value, idx);
    pending_results.push_back(fixed ? want : pred);
    requests_sent++;
    mode_hits[mode]++;
    if (pred.status == ST_EMPTY) empty_hits++;
    if (pred.status == ST_FULL) full_hits++;
    if (pred.status == ST_RANGE) range_hits++;
    if (pred.moved) moved_hits++;
    if (list_len > peak_len) peak_len = list_len;
  endtask

  task automatic report(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin : result_check
    list_result_t got;
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_data, out_status, out_moved, out_length, out_position};
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending, got 0x%0h", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.data !== want.data) report("data", want.data, got.data);
        if (got.status !== want.status) report("status", want.status, got.status);
        if (got.moved !== want.moved) report("moved", want.moved, got.moved);
        if (got.length !== want.length) report("length", want.length, got.length);
        if (got.position !== want.position) report("position", want.position, got.position);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Output side: random stalls, one long hold-off, one clean stretch
  initial begin : result_drain
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!hold_done && requests_sent >= 450) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (requests_sent >= 600 && requests_sent < 800) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 9);
      end
    end
  end

  initial begin : request_feed
    stim_row_t    dir_tab [$];
    list_result_t at_empty;
    drift_t       drift;
    int           k;
    int           n;

    at_empty = '{32'h0, ST_EMPTY, 1'b0, 5'd0, 4'd0};
    dir_tab.push_back(row(M_READ, 32'h0, 4'd0, 1, 1'b1, at_empty));
    dir_tab.push_back(row(M_PREV, 32'h0, 4'd0, 1, 1'b1, at_empty));
    dir_tab.push_back(row(M_NEXT, 32'h0, 4'd0, 1, 1'b1, at_empty));
    dir_tab.push_back(row(M_FIRST, 32'h0, 4'd0, 1, 1'b1, at_empty));
    dir_tab.push_back(row(M_LAST, 32'h0, 4'd0, 1, 1'b1, at_empty));
    dir_tab.push_back(row(M_DEL, 32'h0, 4'd0, 1, 1'b1, at_empty));
    dir_tab.push_back(row(M_INDEX, 32'h0, 4'd0, 1, 1'b1, at_empty));
    dir_tab.push_back(row(MODE_UNUSED_FIRST, 32'hFFFF_FFFF, 4'd15, 1, 1'b1,
                          '{32'h0, ST_OK, 1'b0, 5'd0, 4'd0}));
    dir_tab.push_back(row(MODE_UNUSED_LAST, 32'h0, 4'd0, 1, 1'b1,
                          '{32'h0, ST_OK, 1'b0, 5'd0, 4'd0}));
    dir_tab.push_back(row(M_INS_A, 32'hFFFF_FFFF, 4'd0, 1, 1'b1,
                          '{32'hFFFF_FFFF, ST_OK, 1'b0, 5'd1, 4'd0}));
    dir_tab.push_back(row(M_INS_B, 32'h0, 4'd0));
    dir_tab.push_back(row(M_PREV, 32'h0, 4'd0));
    dir_tab.push_back(row(M_PREV, 32'h0, 4'd0));
    dir_tab.push_back(row(M_NEXT, 32'h0, 4'd0));
    dir_tab.push_back(row(M_NEXT, 32'h0, 4'd0));
    dir_tab.push_back(row(M_INDEX, 32'h0, 4'd2, 1, 1'b1,
                          '{32'h0, ST_RANGE, 1'b0, 5'd2, 4'd1}));
    dir_tab.push_back(row(M_INDEX, 32'h0, 4'd15, 1, 1'b1,
                          '{32'h0, ST_RANGE, 1'b0, 5'd2, 4'd1}));
    dir_tab.push_back(row(M_INDEX, 32'h0, 4'd0));
    // fill to DEPTH with random words behind the cursor
    dir_tab.push_back(row(M_INS_A, 32'h0, 4'd0, CAL_DEPTH - 2));
    dir_tab.push_back(row(M_INS_B, 32'hA5A5_5A5A, 4'd0, 1, 1'b1,
                          '{32'h0, ST_FULL, 1'b0, 5'(CAL_DEPTH), 4'd1}));
    dir_tab.push_back(row(M_INDEX, 32'h0, 4'd15));
    dir_tab.push_back(row(M_LAST, 32'h0, 4'd0));
    dir_tab.push_back(row(M_DEL, 32'h0, 4'd0));
    dir_tab.push_back(row(M_FIRST, 32'h0, 4'd0));
    dir_tab.push_back(row(M_DEL, 32'h0, 4'd0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      for (n = 0; n < dir_tab[r].reps; n++) begin
        offer(dir_tab[r].mode, (dir_tab[r].reps > 1) ? $urandom : dir_tab[r].value,
              dir_tab[r].index, dir_tab[r].fixed, dir_tab[r].want);
      end
    end

    drift = DRIFT_GROW;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 64 == 0) drift = drift_t'($urandom_range(0, 2));
      if (requests_sent == 900) begin
        // drain everything before going on
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      offer(pick_mode(drift), pick_value(), pick_index(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d requests (%0d deletes, %0d inserts, %0d index reads), %0d results checked",
             requests_sent, mode_hits[M_DEL],
             mode_hits[M_INS_B] + mode_hits[M_INS_A], mode_hits[M_INDEX],
             results_checked);
    $display("Peak length %0d, %0d empty, %0d full, %0d out of range, %0d cursor moves",
             peak_len, empty_hits, full_hits, range_hits, moved_hits);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### cursor_array_list_unit.f
sv/cal_pkg.sv
sv/cal_ram.sv
sv/cursor_array_list_unit.sv
tb/tb_cursor_array_list_unit.sv
